// ----- sv/swm_pkg.sv -----
// Shared constants, types and command/status structures of the sliding-window median unit.
package swm_pkg;

  localparam int WINDOW_MAX  = 64;
  localparam int SAMPLE_BITS = 32;
  localparam int IDX_W       = $clog2(WINDOW_MAX);
  localparam int CNT_W       = IDX_W + 1;
  localparam int CFG_W       = 7;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PICK,
    ST_SHIFT
  } swm_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic insert;
    logic pick;
    logic shift;
  } swm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic window_full;
    logic out_busy;
  } swm_status_t;

endpackage

// ----- sv/swm_ctrl.sv -----
// Controller state machine: sequences insertion, median capture and eviction.
module swm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  swm_pkg::swm_status_t status,
  output swm_pkg::swm_cmd_t    cmd
);

  swm_pkg::swm_state_t state;
  swm_pkg::swm_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      swm_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.insert = 1'b1;
          // The incoming request completes the window, so a result follows.
          if (status.window_full) begin
            state_next = swm_pkg::ST_PICK;
          end
        end
      end
      swm_pkg::ST_PICK: begin
        if (!status.out_busy) begin
          cmd.pick   = 1'b1;
          state_next = swm_pkg::ST_SHIFT;
        end
      end
      swm_pkg::ST_SHIFT: begin
        cmd.shift  = 1'b1;
        state_next = swm_pkg::ST_IDLE;
      end
      default: begin
        state_next = swm_pkg::ST_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd.pick |=> cmd.shift)
    else $error("eviction did not follow median capture");

  assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.insert, cmd.pick, cmd.shift}) <= 1)
    else $error("more than one datapath command at once");

  assert property (@(posedge clk) disable iff (rst)
    cmd.shift |=> s_tready)
    else $error("controller did not return to accepting after eviction");

endmodule

// ----- sv/swm_dp.sv -----
// Datapath: sorted cell row with ages, window length registers and output register.
module swm_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [swm_pkg::CFG_W-1:0]    cfg_wdata,
  input  swm_pkg::sample_t             sample,
  input  swm_pkg::swm_cmd_t            cmd,
  output swm_pkg::swm_status_t         status,
  output logic                         out_valid,
  output swm_pkg::sample_t             out_data,
  input  logic                         out_ready
);

  localparam int N = swm_pkg::WINDOW_MAX;

  swm_pkg::sample_t             val [N];
  logic [swm_pkg::IDX_W-1:0]    age [N];
  logic [swm_pkg::CNT_W-1:0]    fill;
  logic [swm_pkg::IDX_W-1:0]    kmin1;
  logic [swm_pkg::IDX_W-1:0]    med_idx;
  swm_pkg::sample_t             evict_val;

  logic [N-1:0]                 held;
  logic [N-1:0]                 gt;
  logic [N-1:0]                 hit;
  logic [N-1:0]                 shl;
  swm_pkg::sample_t             med_or;
  swm_pkg::sample_t             evict_or;
  logic [swm_pkg::CNT_W-1:0]    k_clamped;

  always_comb begin
    med_or   = '0;
    evict_or = '0;
    for (int i = 0; i < N; i++) begin
      held[i] = swm_pkg::CNT_W'(i) < fill;
      gt[i]   = held[i] && (val[i] > sample);
      hit[i]  = held[i] && (age[i] == kmin1);
      shl[i]  = held[i] && (val[i] >= evict_val);
      if (swm_pkg::IDX_W'(i) == med_idx) begin
        med_or = med_or | val[i];
      end
      if (hit[i]) begin
        evict_or = evict_or | val[i];
      end
    end
  end

  // Window length zero counts as one; anything above the row length counts as full length.
  always_comb begin
    if (cfg_wdata == '0) begin
      k_clamped = swm_pkg::CNT_W'(1);
    end else if (cfg_wdata > swm_pkg::CFG_W'(N)) begin
      k_clamped = swm_pkg::CNT_W'(N);
    end else begin
      k_clamped = swm_pkg::CNT_W'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      kmin1   <= '0;
      med_idx <= '0;
    end else if (cfg_we) begin
      fill    <= '0;
      kmin1   <= swm_pkg::IDX_W'(k_clamped - swm_pkg::CNT_W'(1));
      med_idx <= swm_pkg::IDX_W'((k_clamped - swm_pkg::CNT_W'(1)) >> 1);
    end else if (cmd.insert) begin
      fill <= fill + swm_pkg::CNT_W'(1);
    end else if (cmd.shift) begin
      fill <= fill - swm_pkg::CNT_W'(1);
    end
  end

  // Insertion keeps equal values in arrival order: the new sample lands after its equals.
  // Eviction removes the first cell holding the evicted value, which is its oldest copy.
  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (cmd.insert) begin
        if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
          val[i] <= val[(i > 0) ? i - 1 : 0];
          age[i] <= age[(i > 0) ? i - 1 : 0] + swm_pkg::IDX_W'(1);
        end else if (gt[i] || swm_pkg::CNT_W'(i) == fill) begin
          val[i] <= sample;
          age[i] <= '0;
        end else begin
          age[i] <= age[i] + swm_pkg::IDX_W'(1);
        end
      end else if (cmd.shift && shl[i] && i < N - 1) begin
        val[i] <= val[(i < N - 1) ? i + 1 : i];
        age[i] <= age[(i < N - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      evict_val <= evict_or;
      out_data  <= med_or;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.pick) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.window_full = (fill == swm_pkg::CNT_W'(kmin1));
  assign status.out_busy    = out_valid && !out_ready;

  assert property (@(posedge clk) disable iff (rst)
    cmd.pick |-> $onehot(hit))
    else $error("oldest sample not found exactly once in the window");

  assert property (@(posedge clk) disable iff (rst)
    fill <= swm_pkg::CNT_W'(kmin1) + swm_pkg::CNT_W'(1))
    else $error("fill count beyond window length");

  assert property (@(posedge clk) disable iff (rst)
    cmd.shift |=> fill == swm_pkg::CNT_W'(kmin1))
    else $error("eviction left wrong fill count");

endmodule

// ----- sv/sliding_window_median_unit.sv -----
// Top level of the sliding-window median unit: controller plus sorted-cell datapath.
//
//  channel   direction  handshake              payload
//  s_*       in         s_tvalid / s_tready    s_tdata: sample
//  m_*       out        m_tvalid / m_tready    m_tdata: median_value
//  cfg_*     in         cfg_we                 cfg_wdata: window_size
//
// While the window fills, a request is taken on insert alone; once it completes the window,
// the request runs insert, median capture and eviction before the next one is taken.
// The median capture waits while the output register still holds an untaken result.
// Reset empties the window and sets the length to one; a length write empties it too.
module sliding_window_median_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [31:0]                  s_tdata,   // [31:0] sample
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [31:0]                  m_tdata,   // [31:0] median_value
  input  logic                         cfg_we,
  input  logic [swm_pkg::CFG_W-1:0]    cfg_wdata
);

  swm_pkg::swm_cmd_t    cmd;
  swm_pkg::swm_status_t status;
  swm_pkg::sample_t     out_data;

  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  swm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sample    (swm_pkg::sample_t'(s_tdata)),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_tvalid),
    .out_data  (out_data),
    .out_ready (m_tready)
  );

  assign m_tdata = 32'(out_data);

endmodule
